>>> design/bfha_pkg.sv
// ----------------------------------------------------------------------------
// bfha_pkg
// Shared types and constants of the best-fit heap allocator.
// ----------------------------------------------------------------------------
package bfha_pkg;

    localparam int HEAP_BYTES_DEF   = 4096;
    localparam int ALIGN_BYTES_DEF  = 16;
    localparam int HEADER_BYTES_DEF = 8;
    localparam int WORD_BYTES       = 8;

    localparam logic [31:0] BIT_BUSY     = 32'd1;
    localparam logic [31:0] BIT_PREVBUSY = 32'd2;
    localparam logic [31:0] END_MARK     = 32'd1;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_READ  = 2'd1,
        CMD_ALLOC = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_NOFIT  = 2'd1,
        ST_ZERO   = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_RD_WAIT,
        S_WALK_RD,
        S_WALK_CHK,
        S_HDR_RD,
        S_HDR_CHK,
        S_NXT_RD,
        S_NXT_CHK,
        S_DONE
    } t_state;

    // memory port request from sequencer to store
    typedef struct packed {
        logic        we;
        logic        in_range;
        logic [16:0] byte_off;
        logic [31:0] wdata;
    } t_mem_req;

endpackage

>>> design/bfha_store.sv
// ----------------------------------------------------------------------------
// bfha_store
// Heap word memory: one port, registered read, byte-offset address.
// ----------------------------------------------------------------------------
module bfha_store
    import bfha_pkg::*;
#(
    parameter int WORDS = HEAP_BYTES_DEF / WORD_BYTES
) (
    input  logic        i_clk,
    input  t_mem_req    i_req,
    output logic [31:0] o_rdata
);
    localparam int AW = $clog2(WORDS);

    logic [31:0] r_mem [WORDS];
    logic [AW-1:0] addr;

    assign addr = AW'(i_req.byte_off >> 3);

    // write when in range, read always (out of range reads as zero)
    always_ff @(posedge i_clk) begin
        if (i_req.we && i_req.in_range) begin
            r_mem[addr] <= i_req.wdata;
        end
        o_rdata <= i_req.in_range ? r_mem[addr] : 32'd0;
    end
endmodule

>>> design/best_fit_heap_allocator.sv
// ----------------------------------------------------------------------------
// best_fit_heap_allocator
// Best-fit allocator over an implicit block list held in a heap word memory.
// ----------------------------------------------------------------------------
// Usage: one request channel (command, word_index, word_value, request_bytes)
// and one result channel (status, payload_offset, read_value), each with
// valid and stall; a request is taken when valid is high and stall is low.
// Every request yields exactly one result.
// Sequencing: a write or a zero-size allocate registers its result directly; a
// read waits for the registered memory read; any other allocate reads each block
// header in turn (end mark included), then reports no fit, or rereads the best
// header, marks it busy (splitting off a free block and footer if room), updates
// the next block and registers the result, all through the single memory port.
// One request is worked at a time; the next is taken once the result is
// registered and leaves, at the earliest in the cycle it is taken, so a
// stalled result holds off the next request.
// Reset: a clearing pass writes every heap word (HEAP_BYTES/8 words, 512
// by default) and lays down the initial free block, footer and end mark;
// no request is taken during it. A stalled result holds until taken.
// ----------------------------------------------------------------------------
module best_fit_heap_allocator
    import bfha_pkg::*;
#(
    parameter int HEAP_BYTES   = HEAP_BYTES_DEF,
    parameter int ALIGN_BYTES  = ALIGN_BYTES_DEF,
    parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_command,
    input  logic [8:0]  i_word_index,
    input  logic [31:0] i_word_value,
    input  logic [11:0] i_request_bytes,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_status,
    output logic [11:0] o_payload_offset,
    output logic [31:0] o_read_value
);
    localparam int WORDS = HEAP_BYTES / WORD_BYTES;
    localparam int CW    = $clog2(WORDS);
    localparam logic [16:0] HEAP  = 17'(HEAP_BYTES);
    localparam logic [16:0] ALIGN = 17'(ALIGN_BYTES);
    localparam logic [16:0] HDRB  = 17'(HEADER_BYTES);
    localparam logic [16:0] FSZ   = 17'(HEAP_BYTES - ALIGN_BYTES);
    localparam logic [31:0] SMASK = ~32'(ALIGN_BYTES - 1);

    t_state      r_state, n_state;
    logic [CW:0] r_clr, n_clr;
    logic [16:0] r_cur, n_cur, r_best, n_best, r_bsz, n_bsz, r_need, n_need;
    logic        r_found, n_found;
    logic [1:0]  r_step, n_step;
    logic        r_ov, n_ov;
    logic [1:0]  r_st, n_st;
    logic [11:0] r_po, n_po;
    logic [31:0] r_rv, n_rv;
    logic [31:0] r_hdr, n_hdr;
    t_mem_req    req;
    logic [31:0] rdata;
    logic        take, out_free;
    logic [16:0] rest;
    logic [31:0] sz;

    bfha_store #(.WORDS(WORDS)) u_store (
        .i_clk  (i_clk),
        .i_req  (req),
        .o_rdata(rdata)
    );

    assign out_free = !r_ov || !i_stall;
    assign o_stall  = !(r_state == S_IDLE && out_free);
    assign take     = i_valid && !o_stall;
    assign o_valid  = r_ov;
    assign o_status = r_st;
    assign o_payload_offset = r_po;
    assign o_read_value = r_rv;
    assign sz   = rdata & SMASK;
    assign rest = r_bsz - r_need;

    // hold state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_ov    <= 1'b0;
            r_found <= 1'b0;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_ov    <= n_ov;
            r_found <= n_found;
            r_step  <= n_step;
        end
        r_cur <= n_cur; r_best <= n_best; r_bsz <= n_bsz; r_need <= n_need;
        r_st <= n_st; r_po <= n_po; r_rv <= n_rv; r_hdr <= n_hdr;
    end

    // sequence the walk, split and updates
    always_comb begin
        n_state = r_state; n_clr = r_clr; n_cur = r_cur; n_best = r_best;
        n_bsz = r_bsz; n_need = r_need; n_found = r_found; n_step = r_step;
        n_st = r_st; n_po = r_po; n_rv = r_rv; n_hdr = r_hdr;
        n_ov = r_ov && i_stall;
        req = '{we: 1'b0, in_range: 1'b0, byte_off: '0, wdata: '0};
        unique case (r_state)
            S_CLEAR: begin
                req.we = 1'b1; req.in_range = 1'b1;
                req.byte_off = 17'({r_clr[CW-1:0], 3'b000});
                if (req.byte_off == 17'd0) req.wdata = 32'(FSZ) | BIT_PREVBUSY;
                else if (req.byte_off == FSZ - HDRB) req.wdata = 32'(FSZ);
                else if (req.byte_off == FSZ) req.wdata = END_MARK;
                n_clr = r_clr + 1'b1;
                if (r_clr == (CW+1)'(WORDS - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (take) begin
                    n_st = ST_OK; n_po = '0; n_rv = '0;
                    req.byte_off = 17'({i_word_index, 3'b000});
                    req.in_range = 32'(i_word_index) < WORDS;
                    req.wdata = i_word_value;
                    unique case (t_cmd'(i_command))
                        CMD_WRITE: begin req.we = 1'b1; n_ov = 1'b1; end
                        CMD_READ:  n_state = S_RD_WAIT;
                        CMD_ALLOC: begin
                            if (i_request_bytes == '0) begin
                                n_st = ST_ZERO; n_ov = 1'b1;
                            end else begin
                                n_need = ((17'(i_request_bytes) + HDRB + ALIGN - 17'd1)
                                          / ALIGN) * ALIGN;
                                n_cur = '0; n_found = 1'b0;
                                n_state = S_WALK_RD;
                            end
                        end
                        default: n_ov = 1'b1;
                    endcase
                end
            end
            S_RD_WAIT: begin
                n_rv = rdata; n_ov = 1'b1; n_state = S_IDLE;
            end
            S_WALK_RD: begin
                if (r_cur + HDRB <= HEAP) begin
                    req.byte_off = r_cur; req.in_range = 1'b1;
                    n_state = S_WALK_CHK;
                end else n_state = S_HDR_RD;
            end
            S_WALK_CHK: begin
                if (rdata == END_MARK || sz == 32'd0 ||
                    33'(r_cur) + 33'(sz) > 33'(HEAP)) begin
                    n_state = S_HDR_RD;
                end else begin
                    if (!rdata[0] && sz >= 32'(r_need) &&
                        (!r_found || sz < 32'(r_bsz))) begin
                        n_found = 1'b1; n_best = r_cur; n_bsz = 17'(sz);
                    end
                    n_cur = r_cur + 17'(sz);
                    n_state = S_WALK_RD;
                end
            end
            S_HDR_RD: begin
                if (!r_found) begin
                    n_st = ST_NOFIT; n_ov = 1'b1; n_state = S_IDLE;
                end else begin
                    req.byte_off = r_best; req.in_range = 1'b1;
                    n_state = S_HDR_CHK; n_step = '0;
                end
            end
            S_HDR_CHK: begin
                // on a split write header, new free header, footer over successive cycles; else mark the block busy
                if (r_step == 2'd0) n_hdr = rdata;
                req.we = 1'b1;
                if (rest >= ALIGN + HDRB) begin
                    priority case (r_step)
                        2'd0: begin
                            req.byte_off = r_best;
                            req.wdata = 32'(r_need) | BIT_BUSY | (rdata & BIT_PREVBUSY);
                        end
                        2'd1: begin
                            req.byte_off = r_best + r_need;
                            req.wdata = 32'(rest) | BIT_PREVBUSY;
                        end
                        default: begin
                            req.byte_off = r_best + r_bsz - HDRB;
                            req.wdata = 32'(rest);
                        end
                    endcase
                    req.in_range = (req.byte_off >> 3) < 17'(WORDS);
                    n_step = r_step + 2'd1;
                    if (r_step == 2'd2) begin
                        n_cur = r_best + r_need; n_state = S_NXT_RD;
                    end
                end else begin
                    req.byte_off = r_best; req.in_range = 1'b1;
                    req.wdata = rdata | BIT_BUSY;
                    n_cur = r_best + r_bsz; n_state = S_NXT_RD;
                end
            end
            S_NXT_RD: begin
                if (r_cur + HDRB <= HEAP) begin
                    req.byte_off = r_cur; req.in_range = 1'b1;
                    n_state = S_NXT_CHK;
                end else n_state = S_DONE;
            end
            S_NXT_CHK: begin
                req.byte_off = r_cur; req.in_range = 1'b1;
                req.we = (rdata != END_MARK);
                req.wdata = rdata | BIT_PREVBUSY;
                n_state = S_DONE;
            end
            S_DONE: begin
                n_po = 12'(r_best + HDRB);
                n_ov = 1'b1; n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule
